// File: src/ncbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncbs_pkg
// shared types and rotation coefficients for the nearest cluster box selector
// ----------------------------------------------------------------------------
package ncbs_pkg;

  localparam int CoordW = 16;
  localparam int RobotW = 17;
  localparam int ProdW  = 32;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [RobotW-1:0] robot_t;

  // camera-frame box, index 0..2 is x, y, z
  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } box_t;

  // robot-frame box
  typedef struct packed {
    robot_t [2:0] lo;
    robot_t [2:0] hi;
  } rbox_t;

  // control carried alongside the box through the transform stages
  typedef struct packed {
    logic       close;
    logic       fe;
    logic [7:0] number;
  } tag_t;

  // q2.14 rotation matrix, rows are robot axes
  function automatic logic signed [CoordW-1:0] rot_coef(input logic [1:0] row,
                                                        input logic [1:0] col);
    logic signed [CoordW-1:0] c;
    c = '0;
    case ({row, col})
      4'h0:    c = 16'sd16381;
      4'h1:    c = -16'sd120;
      4'h2:    c = -16'sd268;
      4'h4:    c = 16'sd119;
      4'h5:    c = 16'sd16383;
      4'h6:    c = -16'sd52;
      4'h8:    c = 16'sd268;
      4'h9:    c = 16'sd50;
      4'hA:    c = 16'sd16382;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/ncbs_xform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncbs_xform
// size check and camera-to-robot transform of a closed box, two stages
// ----------------------------------------------------------------------------
module ncbs_xform (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             en,
  input  wire                             a_vld,
  input  ncbs_pkg::tag_t                  a_tag,
  input  ncbs_pkg::box_t                  a_box,
  input  wire  [15:0]                     min_box,
  input  wire  [15:0]                     max_box,
  input  wire  [2:0][15:0]                trans,
  output logic                            c_vld,
  output ncbs_pkg::tag_t                  c_tag,
  output logic                            c_ok,
  output ncbs_pkg::rbox_t                 c_box,
  output ncbs_pkg::coord_t                c_depth
);

  localparam int AccW = 34;
  localparam int QW   = AccW - 14;
  localparam int TW   = QW + 1;

  // stage b: size check and products
  logic                             b_vld_r;
  ncbs_pkg::tag_t                   b_tag_r;
  logic                             b_ok_r, b_ok_nxt;
  logic [1:0][2:0][2:0][31:0]       b_prod_r, b_prod_nxt;
  ncbs_pkg::coord_t                 b_depth_r;

  // stage c: robot box
  logic                             c_vld_r;
  ncbs_pkg::tag_t                   c_tag_r;
  logic                             c_ok_r;
  ncbs_pkg::rbox_t                  c_box_r, c_box_nxt;
  ncbs_pkg::coord_t                 c_depth_r;

  function automatic ncbs_pkg::robot_t sat17(input logic signed [TW-1:0] v);
    ncbs_pkg::robot_t r;
    if (v < -21'sd65536) begin
      r = 17'h10000;
    end else if (v > 21'sd65535) begin
      r = 17'h0FFFF;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  always_comb begin
    logic [16:0] sz;
    ncbs_pkg::coord_t pt;
    b_ok_nxt   = 1'b1;
    b_prod_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      sz = {a_box.hi[a][15], a_box.hi[a]} - {a_box.lo[a][15], a_box.lo[a]};
      if (sz[15:0] < min_box || sz[15:0] > max_box) begin
        b_ok_nxt = 1'b0;
      end
    end
    for (int k = 0; k < 2; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pt = (k == 0) ? a_box.lo[c] : a_box.hi[c];
          b_prod_nxt[k][r][c] = 32'(ncbs_pkg::rot_coef(2'(r), 2'(c)))
                              * 32'($signed(pt));
        end
      end
    end
  end

  always_comb begin
    logic signed [AccW-1:0] acc;
    logic signed [QW-1:0]   q;
    logic signed [TW-1:0]   t;
    logic [1:0][16:0]       rv;
    c_box_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 2; k++) begin
        acc = $signed({{2{b_prod_r[k][r][0][31]}}, b_prod_r[k][r][0]})
            + $signed({{2{b_prod_r[k][r][1][31]}}, b_prod_r[k][r][1]})
            + $signed({{2{b_prod_r[k][r][2][31]}}, b_prod_r[k][r][2]})
            + 34'sd8192;
        q = acc[AccW-1:14];
        t = $signed({q[QW-1], q}) + $signed({{(TW-16){trans[r][15]}}, trans[r]});
        rv[k] = sat17(t);
      end
      if ($signed(rv[0]) < $signed(rv[1])) begin
        c_box_nxt.lo[r] = rv[0];
        c_box_nxt.hi[r] = rv[1];
      end else begin
        c_box_nxt.lo[r] = rv[1];
        c_box_nxt.hi[r] = rv[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_tag_r   <= a_tag;
      b_ok_r    <= b_ok_nxt;
      b_prod_r  <= b_prod_nxt;
      b_depth_r <= a_box.lo[2];
      c_tag_r   <= b_tag_r;
      c_ok_r    <= b_ok_r;
      c_box_r   <= c_box_nxt;
      c_depth_r <= b_depth_r;
    end
  end

  assign c_vld   = c_vld_r;
  assign c_tag   = c_tag_r;
  assign c_ok    = c_ok_r;
  assign c_box   = c_box_r;
  assign c_depth = c_depth_r;

endmodule
`default_nettype wire

// File: src/nearest_cluster_box_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_cluster_box_selector
// tracks per-cluster point boxes and reports the nearest robot-frame box
// ----------------------------------------------------------------------------
// result path: after acceptance a frame_end transfer passes the box merge,
//   products, robot box and selection into out reg stages to the out channel
// throughput: one item per cycle; input stalls only while a result waits in
//   the output register and the next frame_end reaches the selection stage
// reset: synchronous active-low rst_n clears control state and loads register
//   defaults; box and result payload registers are not reset
module nearest_cluster_box_selector #(
  parameter int MAX_CLUSTERS = 256
) (
  input  wire          clk,
  input  wire          rst_n,
  // [15:0] pt_x, [31:16] pt_y, [47:32] pt_z, [48] cluster_end, [55:49] zero
  input  wire  [55:0]  in_tdata,
  // [0] has_point
  input  wire          in_tuser,
  // frame_end
  input  wire          in_tlast,
  input  wire          in_tvalid,
  output logic         in_tready,
  // [7:0] cluster_number, [24:8] near_min_x, [41:25] near_min_y,
  // [58:42] near_min_z, [75:59] near_max_x, [92:76] near_max_y,
  // [109:93] near_max_z, [125:110] camera_depth, [127:126] zero
  output logic [127:0] out_tdata,
  // [0] found
  output logic         out_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [4:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int CapInt = (MAX_CLUSTERS - 1 > 255) ? 255 : MAX_CLUSTERS - 1;
  localparam logic [7:0] COUNT_CAP = 8'(CapInt);

  localparam logic [2:0] REG_MIN_BOX = 3'd0;
  localparam logic [2:0] REG_MAX_BOX = 3'd1;
  localparam logic [2:0] REG_TRANS_X = 3'd2;
  localparam logic [2:0] REG_TRANS_Y = 3'd3;
  localparam logic [2:0] REG_TRANS_Z = 3'd4;

  // configuration
  logic [15:0]      min_box_r, max_box_r;
  logic [2:0][15:0] trans_r;
  logic             cfg_wr;

  // running box and frame control
  ncbs_pkg::box_t   run_r, merged;
  logic             open_r;
  logic [7:0]       count_r;

  // stage a
  logic             a_vld_r;
  ncbs_pkg::tag_t   a_tag_r;
  ncbs_pkg::box_t   a_box_r;

  // transform outputs
  logic             c_vld;
  ncbs_pkg::tag_t   c_tag;
  logic             c_ok;
  ncbs_pkg::rbox_t  c_box;
  ncbs_pkg::coord_t c_depth;

  // kept box
  logic             best_found_r;
  logic [7:0]       best_number_r;
  ncbs_pkg::rbox_t  best_box_r;
  ncbs_pkg::coord_t best_depth_r;

  // output register
  logic             out_tvalid_r;
  logic [127:0]     out_tdata_r;
  logic             out_tuser_r;

  logic             en, accept, hp, cl_end, fr_end, open_after, closing;
  logic             take, found_f;
  logic [7:0]       num_f;
  ncbs_pkg::rbox_t  box_f;
  ncbs_pkg::coord_t depth_f;
  logic [2:0][15:0] pt;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_box_r  <= 16'd50;
      max_box_r  <= 16'd2000;
      trans_r[0] <= -16'sd25;
      trans_r[1] <= -16'sd121;
      trans_r[2] <= 16'sd5;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_MIN_BOX: min_box_r  <= cfg_pwdata[15:0];
        REG_MAX_BOX: max_box_r  <= cfg_pwdata[15:0];
        REG_TRANS_X: trans_r[0] <= cfg_pwdata[15:0];
        REG_TRANS_Y: trans_r[1] <= cfg_pwdata[15:0];
        REG_TRANS_Z: trans_r[2] <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_MIN_BOX: cfg_prdata = {16'd0, min_box_r};
      REG_MAX_BOX: cfg_prdata = {16'd0, max_box_r};
      REG_TRANS_X: cfg_prdata = {{16{trans_r[0][15]}}, trans_r[0]};
      REG_TRANS_Y: cfg_prdata = {{16{trans_r[1][15]}}, trans_r[1]};
      REG_TRANS_Z: cfg_prdata = {{16{trans_r[2][15]}}, trans_r[2]};
      default:     cfg_prdata = '0;
    endcase
  end

  // flow control
  assign en        = !(c_vld && c_tag.fe && out_tvalid_r && !out_tready);
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;

  assign hp         = in_tuser;
  assign cl_end     = in_tdata[48];
  assign fr_end     = in_tlast;
  assign pt[0]      = in_tdata[15:0];
  assign pt[1]      = in_tdata[31:16];
  assign pt[2]      = in_tdata[47:32];
  assign open_after = open_r || hp;
  assign closing    = (cl_end || fr_end) && open_after;

  always_comb begin
    merged = run_r;
    for (int a = 0; a < 3; a++) begin
      if (hp && (!open_r || $signed(pt[a]) < $signed(run_r.lo[a]))) begin
        merged.lo[a] = pt[a];
      end
      if (hp && (!open_r || $signed(pt[a]) > $signed(run_r.hi[a]))) begin
        merged.hi[a] = pt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      count_r <= '0;
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= accept && (closing || fr_end);
      if (accept) begin
        open_r <= open_after && !closing;
        if (fr_end) begin
          count_r <= '0;
        end else if (closing && count_r < COUNT_CAP) begin
          count_r <= count_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && accept) begin
      if (hp) begin
        run_r <= merged;
      end
      a_box_r        <= merged;
      a_tag_r.close  <= closing;
      a_tag_r.fe     <= fr_end;
      a_tag_r.number <= count_r;
    end
  end

  ncbs_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .a_vld   (a_vld_r),
    .a_tag   (a_tag_r),
    .a_box   (a_box_r),
    .min_box (min_box_r),
    .max_box (max_box_r),
    .trans   (trans_r),
    .c_vld   (c_vld),
    .c_tag   (c_tag),
    .c_ok    (c_ok),
    .c_box   (c_box),
    .c_depth (c_depth)
  );

  // selection
  assign take = c_vld && c_tag.close && c_ok &&
                (!best_found_r || $signed(c_box.lo[0]) < $signed(best_box_r.lo[0]));

  assign found_f = best_found_r || take;
  assign num_f   = take ? c_tag.number : best_number_r;
  assign box_f   = take ? c_box : best_box_r;
  assign depth_f = take ? c_depth : best_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r  <= 1'b0;
      best_number_r <= '0;
    end else if (en && c_vld) begin
      if (c_tag.fe) begin
        best_found_r  <= 1'b0;
        best_number_r <= '0;
      end else if (take) begin
        best_found_r  <= 1'b1;
        best_number_r <= c_tag.number;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      best_box_r   <= c_box;
      best_depth_r <= c_depth;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en && c_vld && c_tag.fe) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_vld && c_tag.fe) begin
      out_tuser_r <= found_f;
      if (found_f) begin
        out_tdata_r <= {2'b00, depth_f, box_f.hi[2], box_f.hi[1], box_f.hi[0],
                        box_f.lo[2], box_f.lo[1], box_f.lo[0], num_f};
      end else begin
        out_tdata_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("empty result carries nonzero data");

  a_stall_only_on_held_result : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a held result");

  a_frame_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fr_end) |=> (count_r == '0 && !open_r))
    else $error("frame end did not clear cluster state");

  a_count_capped : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_CAP)
    else $error("cluster count above cap");

  a_number_idle_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !best_found_r |-> (best_number_r == '0))
    else $error("kept number set without a kept box");

endmodule
`default_nettype wire

// File: bench/nearest_cluster_box_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_cluster_box_selector_tb
// drives clustered camera points through the selector and checks every frame
// result against an in-bench model of box tracking, size filtering, rotation,
// translation, saturation and nearest-box choice; registers go through apb
// ----------------------------------------------------------------------------
module nearest_cluster_box_selector_tb;

  localparam int MaxClusters = 256;
  localparam int CountCap = (MaxClusters - 1) > 255 ? 255 : MaxClusters - 1;
  localparam int RegMinBox = 0;
  localparam int RegMaxBox = 1;
  localparam int RegTransX = 2;
  localparam int RegTransY = 3;
  localparam int RegTransZ = 4;
  localparam int RotQ14 [0:8] = '{16381, -120, -268, 119, 16383, -52, 268, 50, 16382};

  typedef struct packed {
    logic             has_point;
    ncbs_pkg::coord_t x;
    ncbs_pkg::coord_t y;
    ncbs_pkg::coord_t z;
    logic             cl_end;
    logic             fr_end;
  } point_item_t;

  typedef struct packed {
    logic                   found;
    logic [7:0]             number;
    ncbs_pkg::robot_t [2:0] lo;
    ncbs_pkg::robot_t [2:0] hi;
    ncbs_pkg::coord_t       depth;
  } box_result_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic [55:0]   in_tdata = '0;
  logic          in_tuser = 1'b0;
  logic          in_tlast = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [127:0]  out_tdata;
  logic          out_tuser;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [4:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  nearest_cluster_box_selector #(.MAX_CLUSTERS(MaxClusters)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // model copy of registers and frame state
  int lim_lo = 50;
  int lim_hi = 2000;
  int shift_mm [3] = '{-25, -121, 5};
  int run_lo [3];
  int run_hi [3];
  bit box_open = 1'b0;
  int n_boxes = 0;
  bit have_best = 1'b0;
  int best_lo [3];
  int best_hi [3];
  int best_num = 0;
  int best_depth = 0;

  point_item_t point_stream [$];
  box_result_t want_boxes [$];
  point_item_t in_flight;
  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int tx_wait = 0;
  bit tx_busy = 1'b0;
  int rx_wait = 0;
  bit rx_busy = 1'b1;
  logic hold_go = 1'b0;
  int hold_left = 0;
  string axis_tag [3] = '{"x", "y", "z"};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic int to_robot_axis(int row, int p0, int p1, int p2);
    longint acc;
    acc = longint'(RotQ14[3*row]) * p0 + longint'(RotQ14[3*row+1]) * p1
        + longint'(RotQ14[3*row+2]) * p2;
    // round to nearest, ties toward positive infinity
    acc = ((acc + 8192) >>> 14) + shift_mm[row];
    if (acc < -65536) acc = -65536;
    if (acc > 65535) acc = 65535;
    return int'(acc);
  endfunction

  function automatic void close_box();
    bit ok;
    int a;
    int sz;
    int u;
    int v;
    int lo [3];
    int hi [3];
    ok = 1'b1;
    for (a = 0; a < 3; a++) begin
      sz = run_hi[a] - run_lo[a];
      if (sz < lim_lo || sz > lim_hi) ok = 1'b0;
    end
    if (ok) begin
      for (a = 0; a < 3; a++) begin
        u = to_robot_axis(a, run_lo[0], run_lo[1], run_lo[2]);
        v = to_robot_axis(a, run_hi[0], run_hi[1], run_hi[2]);
        lo[a] = u < v ? u : v;
        hi[a] = u < v ? v : u;
      end
      // strictly nearer only, earlier box wins a tie
      if (!have_best || lo[0] < best_lo[0]) begin
        have_best = 1'b1;
        best_lo = lo;
        best_hi = hi;
        best_num = n_boxes;
        best_depth = run_lo[2];
      end
    end
    if (n_boxes < CountCap) n_boxes++;
    box_open = 1'b0;
  endfunction

  function automatic void select_nearest(point_item_t it);
    int pt [3];
    int a;
    box_result_t r;
    if (it.has_point) begin
      pt[0] = int'($signed(it.x));
      pt[1] = int'($signed(it.y));
      pt[2] = int'($signed(it.z));
      for (a = 0; a < 3; a++) begin
        if (!box_open || pt[a] < run_lo[a]) run_lo[a] = pt[a];
        if (!box_open || pt[a] > run_hi[a]) run_hi[a] = pt[a];
      end
      box_open = 1'b1;
    end
    if ((it.cl_end || it.fr_end) && box_open) close_box();
    if (it.fr_end) begin
      r = '0;
      if (have_best) begin
        r.found = 1'b1;
        r.number = best_num[7:0];
        for (a = 0; a < 3; a++) begin
          r.lo[a] = best_lo[a][16:0];
          r.hi[a] = best_hi[a][16:0];
        end
        r.depth = best_depth[15:0];
      end
      want_boxes = {want_boxes, r};
      box_open = 1'b0;
      n_boxes = 0;
      have_best = 1'b0;
      best_num = 0;
    end
  endfunction

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        select_nearest(in_flight);
        n_accepted++;
        if ($urandom_range(0, 11) == 0) tx_busy = !tx_busy;
        tx_wait = tx_busy ? $urandom_range(0, 16) : 0;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (point_stream.size() > 0) begin
          in_flight = point_stream.pop_front();
          in_tdata <= {7'd0, in_flight.cl_end, in_flight.z, in_flight.y, in_flight.x};
          in_tuser <= in_flight.has_point;
          in_tlast <= in_flight.fr_end;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_box();
    box_result_t got;
    box_result_t want;
    int a;
    got.found = out_tuser;
    got.number = out_tdata[7:0];
    for (a = 0; a < 3; a++) begin
      got.lo[a] = out_tdata[8 + 17*a +: 17];
      got.hi[a] = out_tdata[59 + 17*a +: 17];
    end
    got.depth = out_tdata[125:110];
    if (want_boxes.size() == 0) begin
      flag_mismatch("result transfer with no frame end pending");
      return;
    end
    want = want_boxes.pop_front();
    check_field("found", int'(got.found), int'(want.found));
    check_field("cluster_number", int'(got.number), int'(want.number));
    for (a = 0; a < 3; a++) begin
      check_field({"near_min_", axis_tag[a]}, int'($signed(got.lo[a])),
                  int'($signed(want.lo[a])));
      check_field({"near_max_", axis_tag[a]}, int'($signed(got.hi[a])),
                  int'($signed(want.hi[a])));
    end
    check_field("camera_depth", int'($signed(got.depth)), int'($signed(want.depth)));
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_box();
        if ($urandom_range(0, 9) == 0) rx_busy = !rx_busy;
        rx_wait = rx_busy ? $urandom_range(0, 16) : 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        if (out_tvalid) rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input int idx, input logic [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx * 4);
    cfg_pwdata <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      RegMinBox: lim_lo = int'(val);
      RegMaxBox: lim_hi = int'(val);
      RegTransX: shift_mm[0] = int'($signed(val));
      RegTransY: shift_mm[1] = int'($signed(val));
      RegTransZ: shift_mm[2] = int'($signed(val));
      default: ;
    endcase
    // read back
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== val)
      flag_mismatch($sformatf("register %0d read %h want %h", idx, cfg_prdata[15:0], val));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic push_item(input bit hp, input int x, input int y, input int z,
                           input bit ce, input bit fe);
    point_item_t it;
    it.has_point = hp;
    it.x = x[15:0];
    it.y = y[15:0];
    it.z = z[15:0];
    it.cl_end = ce;
    it.fr_end = fe;
    point_stream = {point_stream, it};
    n_queued++;
  endtask

  function automatic int clip16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  task automatic set_translation(input logic [15:0] tx, input logic [15:0] ty,
                                 input logic [15:0] tz);
    write_reg(RegTransX, tx);
    write_reg(RegTransY, ty);
    write_reg(RegTransZ, tz);
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || want_boxes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic queue_frame(input int most);
    int n;
    int k;
    int j;
    int np;
    int spread;
    int ending;
    int cx;
    int cy;
    int cz;
    int x;
    int y;
    int z;
    bit fe_here;
    bit fe_done;
    n = $urandom_range(0, most);
    fe_here = $urandom_range(0, 2) == 0;
    fe_done = 1'b0;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        push_item(1'b0, $urandom, $urandom, $urandom, $urandom_range(0, 1), 1'b0);
      np = $urandom_range(1, 5);
      spread = $urandom_range(0, 3) == 0 ? 4000 : 1500;
      cx = $urandom_range(0, 50000) - 25000;
      cy = $urandom_range(0, 50000) - 25000;
      cz = $urandom_range(0, 50000) - 25000;
      ending = $urandom_range(0, 5);
      for (j = 0; j < np; j++) begin
        if ($urandom_range(0, 15) == 0) begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end else begin
          x = clip16(cx + $urandom_range(0, spread));
          y = clip16(cy + $urandom_range(0, spread));
          z = clip16(cz + $urandom_range(0, spread));
        end
        if (j == np - 1 && k == n - 1 && ending != 0 && fe_here) begin
          push_item(1'b1, x, y, z, ending >= 2, 1'b1);
          fe_done = 1'b1;
        end else begin
          push_item(1'b1, x, y, z, j == np - 1 && ending >= 2, 1'b0);
        end
      end
      // close as an item of its own
      if (ending == 0) begin
        push_item(1'b0, $urandom, $urandom, $urandom, 1'b1, k == n - 1 && fe_here);
        if (k == n - 1 && fe_here) fe_done = 1'b1;
      end
    end
    if (!fe_done) push_item(1'b0, $urandom, $urandom, $urandom, $urandom_range(0, 1), 1'b1);
  endtask

  initial begin
    int ph;
    int base;
    int k;
    logic [15:0] lo_mm;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers
    push_item(1'b0, 0, 0, 0, 1'b0, 1'b1);          // empty frame
    push_item(1'b0, 0, 0, 0, 1'b1, 1'b0);          // close with nothing open
    push_item(1'b1, 100, 200, 800, 1'b0, 1'b0);
    push_item(1'b1, 400, 500, 1100, 1'b1, 1'b0);
    push_item(1'b1, 0, 0, 900, 1'b1, 1'b0);        // single point, too small
    push_item(1'b1, -500, 0, 600, 1'b0, 1'b0);
    push_item(1'b1, -200, 300, 900, 1'b0, 1'b0);
    push_item(1'b0, 0, 0, 0, 1'b1, 1'b0);
    push_item(1'b1, -500, 0, 600, 1'b0, 1'b0);     // tie, earlier box stays
    push_item(1'b1, -200, 300, 900, 1'b1, 1'b0);
    push_item(1'b1, -3000, 0, 0, 1'b0, 1'b0);      // too large on x
    push_item(1'b1, -500, 100, 100, 1'b1, 1'b0);
    push_item(1'b1, -800, 0, 500, 1'b0, 1'b0);
    push_item(1'b1, -750, 50, 550, 1'b0, 1'b1);    // frame end closes open cluster
    push_item(1'b1, 0, 0, 0, 1'b0, 1'b0);
    push_item(1'b1, 2000, 50, 2000, 1'b1, 1'b1);   // sizes at both limits
    push_item(1'b1, 7, 7, 7, 1'b0, 1'b1);
    push_item(1'b1, 10, 10, 10, 1'b0, 1'b0);
    push_item(1'b1, 59, 59, 59, 1'b1, 1'b1);       // just under minimum
    wait_drained();

    write_reg(RegMinBox, 16'd0);
    write_reg(RegMaxBox, 16'hFFFF);
    set_translation(16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_item(1'b1, 32767, -32768, 32767, 1'b0, 1'b0);
    push_item(1'b1, -32768, 32767, -32768, 1'b1, 1'b1);
    push_item(1'b1, 32767, -32768, -32768, 1'b1, 1'b1);
    wait_drained();

    set_translation(16'h8000, 16'h8000, 16'h8000);
    push_item(1'b1, -32768, 32767, 32767, 1'b1, 1'b0);
    push_item(1'b1, 32767, 32767, -32768, 1'b0, 1'b1);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(RegMinBox, 16'd50);
          write_reg(RegMaxBox, 16'd2000);
          set_translation(16'($urandom_range(0, 400)) - 16'd200,
                          16'($urandom_range(0, 400)) - 16'd200,
                          16'($urandom_range(0, 400)) - 16'd200);
        end
        1: begin
          write_reg(RegMinBox, 16'd0);
          write_reg(RegMaxBox, 16'hFFFF);
          set_translation(16'($urandom), 16'($urandom), 16'($urandom));
        end
        2: begin
          write_reg(RegMinBox, 16'd300);
          write_reg(RegMaxBox, 16'd700);
          set_translation(16'($urandom_range(0, 2000)) - 16'd1000,
                          16'($urandom_range(0, 2000)) - 16'd1000,
                          16'($urandom_range(0, 2000)) - 16'd1000);
        end
        3: begin
          write_reg(RegMinBox, 16'hFFFF);
          write_reg(RegMaxBox, 16'd0);
        end
        4: begin
          lo_mm = 16'($urandom_range(0, 400));
          write_reg(RegMinBox, lo_mm);
          write_reg(RegMaxBox, lo_mm + 16'($urandom_range(0, 3000)));
          set_translation(16'($urandom), 16'($urandom_range(0, 400)) - 16'd200,
                          16'($urandom_range(0, 400)) - 16'd200);
        end
        default: begin
          write_reg(RegMinBox, 16'd50);
          write_reg(RegMaxBox, 16'd2000);
          set_translation(-16'sd25, -16'sd121, 16'sd5);
          // receiver stalls while short frames keep arriving
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
      endcase
      base = n_queued;
      while (n_queued - base < 110) queue_frame(ph == 5 ? 2 : 6);
      wait_drained();
    end

    // more clusters than the counter can number, nearest ones past the cap
    write_reg(RegMinBox, 16'd0);
    write_reg(RegMaxBox, 16'hFFFF);
    set_translation(16'($urandom_range(0, 400)) - 16'd200,
                    16'($urandom_range(0, 400)) - 16'd200,
                    16'($urandom_range(0, 400)) - 16'd200);
    for (k = 0; k < 280; k++) begin
      if (k >= 262)
        push_item(1'b1, -32000 + $urandom_range(0, 40), $urandom_range(0, 2000) - 1000,
                  $urandom_range(0, 2000) - 1000, 1'b1, 1'b0);
      else
        push_item(1'b1, $urandom_range(0, 40000) - 20000, $urandom_range(0, 2000) - 1000,
                  $urandom_range(0, 2000) - 1000, 1'b1, 1'b0);
    end
    push_item(1'b0, 0, 0, 0, 1'b0, 1'b1);
    wait_drained();

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: nearest_cluster_box_selector.f
src/ncbs_pkg.sv
src/ncbs_xform.sv
src/nearest_cluster_box_selector.sv
bench/nearest_cluster_box_selector_tb.sv
